// ===== hdl/grp_pkg.sv =====
package grp_pkg;

   localparam int MaxNodes = 256;
   localparam int MaxDim   = 4096;
   localparam int DimW     = 13;
   localparam int SizeW    = 31;
   localparam int AddrW    = $clog2(MaxNodes);
   localparam int CountW   = AddrW + 1;

   localparam logic [SizeW-1:0] RootSize = {SizeW{1'b1}};

   localparam logic [0:0] CsrStartWidth  = 1'b0;
   localparam logic [0:0] CsrStartHeight = 1'b1;

   typedef struct packed {
      logic             dir;
      logic [DimW-1:0]  off_x;
      logic [DimW-1:0]  off_y;
      logic [SizeW-1:0] sz_x;
      logic [SizeW-1:0] sz_y;
   } node_type;

   localparam node_type RootNode = '{dir: 1'b1, off_x: '0, off_y: '0,
                                     sz_x: RootSize, sz_y: RootSize};

   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v == '0) r = DimW'(1);
      else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
      return r;
   endfunction

   // smallest power of two above v, capped
   function automatic logic [DimW-1:0] grow_dim(input logic [DimW-1:0] v);
      logic [DimW:0] p;
      p = '0;
      for (int b = 0; b < DimW; b++) begin
         if (v[b]) p = (DimW+1)'(1) << (b + 1);
      end
      if (p > (DimW+1)'(MaxDim)) p = (DimW+1)'(MaxDim);
      return p[DimW-1:0];
   endfunction

endpackage

// ===== hdl/guillotine_rect_packer_unit.sv =====
// guillotine rectangle packer: each request word (width, height) is placed into
// a growing atlas by best fit over an ordered list of up to 256 free nodes held
// in a single-port-read memory. a request is accepted, then each scan of the node
// list reads one node per cycle through the registered memory read port, judges
// the last read and decides; each atlas growth step is a grow state plus a fresh
// scan. when the winner is removed, the nodes behind it are shifted down one at a
// time, each by a read and a write, then the two remainder nodes are appended and
// the response is registered. the atlas grows in both axes, capped at 4096.
// the block takes no request while one is in work. a request with the table
// full, or with no fit at the largest atlas, returns failed with zero placement
// and the atlas size unchanged. csr writes load the atlas size directly,
// clamped to 1..4096, and are only issued while idle.
module guillotine_rect_packer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [grp_pkg::DimW-1:0]  req_rect_width,
   input  logic [grp_pkg::DimW-1:0]  req_rect_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [grp_pkg::DimW-1:0]  rsp_place_x,
   output logic [grp_pkg::DimW-1:0]  rsp_place_y,
   output logic [grp_pkg::DimW-1:0]  rsp_atlas_width,
   output logic [grp_pkg::DimW-1:0]  rsp_atlas_height,
   output logic                      rsp_failed,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_index,
   input  logic [grp_pkg::DimW-1:0]  csr_write_data
);
   import grp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_GROW = 3'd2;
   localparam logic [2:0] S_SHRD = 3'd3;
   localparam logic [2:0] S_SHWR = 3'd4;
   localparam logic [2:0] S_TNOD = 3'd5;
   localparam logic [2:0] S_LNOD = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [DimW-1:0]   cur_w_ff, cur_w_in, cur_h_ff, cur_h_in;
   logic [DimW-1:0]   sav_w_ff, sav_w_in, sav_h_ff, sav_h_in;
   logic [DimW-1:0]   gx_ff, gx_in, gy_ff, gy_in;
   logic [CountW-1:0] issue_ff, issue_in;     // next node to read
   logic              pend_ff, pend_in;       // read data valid this cycle
   logic [AddrW-1:0]  pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [AddrW-1:0]  best_ff, best_in;
   logic [SizeW-1:0]  best_diff_ff, best_diff_in;
   node_type          best_node_ff, best_node_in;
   logic [AddrW-1:0]  sh_idx_ff, sh_idx_in;
   logic              fail_ff, fail_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DimW-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [DimW-1:0]   rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic              rsp_f_ff, rsp_f_in;

   logic              mem_we;
   logic [AddrW-1:0]  mem_wa, mem_ra;
   node_type          mem_wd, mem_rd;
   logic              ev_qual;
   logic [SizeW-1:0]  ev_diff;
   logic [DimW-1:0]   grow_w, grow_h;
   logic [CountW-1:0] sh_next;
   node_type          t_node, l_node;

   grp_node_mem u_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (mem_we),
      .wr_addr(mem_wa),
      .wr_data(mem_wd),
      .rd_addr(mem_ra),
      .rd_data(mem_rd)
   );

   grp_node_eval u_eval (
      .node   (mem_rd),
      .gx     (gx_ff),
      .gy     (gy_ff),
      .aw     (cur_w_ff),
      .ah     (cur_h_ff),
      .qualify(ev_qual),
      .diff   (ev_diff)
   );

   // remainder nodes of the winner
   always_comb begin
      t_node = best_node_ff;
      l_node = best_node_ff;
      t_node.dir = ~best_node_ff.dir;
      l_node.dir = best_node_ff.dir;
      if (best_node_ff.dir) begin
         // runs along y, across is x
         t_node.off_x = best_node_ff.off_x + gx_ff;
         t_node.sz_y  = {{(SizeW-DimW){1'b0}}, gy_ff};
         t_node.sz_x  = best_node_ff.sz_x - {{(SizeW-DimW){1'b0}}, gx_ff};
         l_node.off_y = best_node_ff.off_y + gy_ff;
         l_node.sz_y  = best_node_ff.sz_y - {{(SizeW-DimW){1'b0}}, gy_ff};
      end else begin
         t_node.off_y = best_node_ff.off_y + gy_ff;
         t_node.sz_x  = {{(SizeW-DimW){1'b0}}, gx_ff};
         t_node.sz_y  = best_node_ff.sz_y - {{(SizeW-DimW){1'b0}}, gy_ff};
         l_node.off_x = best_node_ff.off_x + gx_ff;
         l_node.sz_x  = best_node_ff.sz_x - {{(SizeW-DimW){1'b0}}, gx_ff};
      end
   end

   assign grow_w  = grow_dim(cur_w_ff);
   assign grow_h  = grow_dim(cur_h_ff);
   assign sh_next = {1'b0, sh_idx_ff} + CountW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_w_in     = cur_w_ff;
      cur_h_in     = cur_h_ff;
      sav_w_in     = sav_w_ff;
      sav_h_in     = sav_h_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_diff_in = best_diff_ff;
      best_node_in = best_node_ff;
      sh_idx_in    = sh_idx_ff;
      fail_in      = fail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_f_in     = rsp_f_ff;
      mem_we       = 1'b0;
      mem_wa       = sh_idx_ff;
      mem_wd       = mem_rd;
      mem_ra       = issue_ff[AddrW-1:0];
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               gx_in    = req_rect_width;
               gy_in    = req_rect_height;
               sav_w_in = cur_w_ff;
               sav_h_in = cur_h_ff;
               issue_in = '0;
               found_in = 1'b0;
               if (count_ff >= CountW'(MaxNodes)) begin
                  fail_in  = 1'b1;
                  state_in = S_OUT;
               end else begin
                  fail_in  = 1'b0;
                  state_in = S_SCAN;
               end
            end else if (csr_write_enable) begin
               if (csr_index == {7'd0, CsrStartWidth}) begin
                  cur_w_in = clamp_dim(csr_write_data);
               end else if (csr_index == {7'd0, CsrStartHeight}) begin
                  cur_h_in = clamp_dim(csr_write_data);
               end
            end
         end
         S_SCAN: begin
            // read one node per cycle, judge the one read last cycle
            if (issue_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[AddrW-1:0];
               issue_in    = issue_ff + CountW'(1);
            end
            if (pend_ff && ev_qual && (!found_ff || ev_diff < best_diff_ff)) begin
               found_in     = 1'b1;
               best_in      = pend_idx_ff;
               best_diff_in = ev_diff;
               best_node_in = mem_rd;
            end
            if (!pend_ff && issue_ff >= count_ff) begin
               if (found_ff) begin
                  sh_idx_in = best_ff;
                  state_in  = S_SHRD;
               end else begin
                  state_in  = S_GROW;
               end
            end
         end
         S_GROW: begin
            issue_in = '0;
            if (grow_w == cur_w_ff && grow_h == cur_h_ff) begin
               cur_w_in = sav_w_ff;
               cur_h_in = sav_h_ff;
               fail_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               cur_w_in = grow_w;
               cur_h_in = grow_h;
               state_in = S_SCAN;
            end
         end
         S_SHRD: begin
            mem_ra = sh_next[AddrW-1:0];
            if (sh_next >= count_ff) state_in = S_TNOD;
            else                     state_in = S_SHWR;
         end
         S_SHWR: begin
            mem_we    = 1'b1;
            mem_wa    = sh_idx_ff;
            mem_wd    = mem_rd;
            sh_idx_in = sh_next[AddrW-1:0];
            state_in  = S_SHRD;
         end
         S_TNOD: begin
            mem_we   = 1'b1;
            mem_wa   = AddrW'(count_ff - CountW'(1));
            mem_wd   = t_node;
            state_in = S_LNOD;
         end
         S_LNOD: begin
            mem_we   = 1'b1;
            mem_wa   = count_ff[AddrW-1:0];
            mem_wd   = l_node;
            count_in = count_ff + CountW'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            // wait for the response slot to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = fail_ff ? '0 : best_node_ff.off_x;
               rsp_y_in     = fail_ff ? '0 : best_node_ff.off_y;
               rsp_w_in     = cur_w_ff;
               rsp_h_in     = cur_h_ff;
               rsp_f_in     = fail_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CountW'(1);
         cur_w_ff     <= DimW'(256);
         cur_h_ff     <= DimW'(256);
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_w_ff     <= cur_w_in;
         cur_h_ff     <= cur_h_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sav_w_ff     <= sav_w_in;
      sav_h_ff     <= sav_h_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      best_ff      <= best_in;
      best_diff_ff <= best_diff_in;
      best_node_ff <= best_node_in;
      sh_idx_ff    <= sh_idx_in;
      fail_ff      <= fail_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_w_ff     <= rsp_w_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_f_ff     <= rsp_f_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_place_x      = rsp_x_ff;
   assign rsp_place_y      = rsp_y_ff;
   assign rsp_atlas_width  = rsp_w_ff;
   assign rsp_atlas_height = rsp_h_ff;
   assign rsp_failed       = rsp_f_ff;
endmodule

// ===== hdl/grp_node_mem.sv =====
module grp_node_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [grp_pkg::AddrW-1:0] wr_addr,
   input  grp_pkg::node_type     wr_data,
   input  logic [grp_pkg::AddrW-1:0] rd_addr,
   output grp_pkg::node_type     rd_data
);
   import grp_pkg::*;

   node_type mem [MaxNodes];
   node_type rd_data_ff;

   // root node is written on reset, the rest is left alone
   always_ff @(posedge clock) begin
      if (reset) begin
         mem[0] <= RootNode;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/grp_node_eval.sv =====
module grp_node_eval (
   input  grp_pkg::node_type         node,
   input  logic [grp_pkg::DimW-1:0]  gx,
   input  logic [grp_pkg::DimW-1:0]  gy,
   input  logic [grp_pkg::DimW-1:0]  aw,
   input  logic [grp_pkg::DimW-1:0]  ah,
   output logic                      qualify,
   output logic [grp_pkg::SizeW-1:0] diff
);
   import grp_pkg::*;

   logic [DimW:0] end_x, end_y;
   logic          fit_size, fit_atlas;

   always_comb begin
      end_x     = {1'b0, node.off_x} + {1'b0, gx};
      end_y     = {1'b0, node.off_y} + {1'b0, gy};
      fit_size  = ({{(SizeW-DimW){1'b0}}, gx} <= node.sz_x) &&
                  ({{(SizeW-DimW){1'b0}}, gy} <= node.sz_y);
      fit_atlas = (end_x <= {1'b0, aw}) && (end_y <= {1'b0, ah});
      qualify   = fit_size && fit_atlas;
      // across axis is y for direction 0, x for direction 1
      if (node.dir) diff = node.sz_x - {{(SizeW-DimW){1'b0}}, gx};
      else          diff = node.sz_y - {{(SizeW-DimW){1'b0}}, gy};
   end
endmodule
